/* design/mrf_pkg.sv */
`default_nettype none

package mrf_pkg;

   // register kinds
   localparam logic [1:0] KIND_COILS   = 2'd0;
   localparam logic [1:0] KIND_HOLDING = 2'd1;

   // function codes
   localparam logic [7:0] FC_NONE           = 8'h00;
   localparam logic [7:0] FC_READ_COILS     = 8'h01;
   localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
   localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
   localparam logic [7:0] FC_WRITE_REG      = 8'h06;
   localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;

   localparam logic [7:0]  COIL_ON_SINGLE = 8'hFF;
   localparam logic [7:0]  COIL_ON_MULTI  = 8'h0F;
   localparam logic [7:0]  COIL_BYTE_CNT  = 8'h01;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;

   localparam int          BODY_MAX = 8;   // bytes ahead of the CRC

   typedef struct packed {
      logic [1:0]  reg_kind;
      logic        write_req;
      logic [7:0]  server_address;
      logic [15:0] start_address;
      logic [15:0] value_count;
      logic [15:0] first_value;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   // frame in flight: bytes to send, CRC so far, bytes still to fold into the CRC
   typedef struct packed {
      logic [BODY_MAX-1:0][7:0] data;
      logic [3:0]               len;
      logic [15:0]              crc;
      logic [BODY_MAX-1:0][7:0] pend;
      logic [3:0]               pend_cnt;
   } frame_type;

   // CRC-16/Modbus table entry, reflected polynomial
   function automatic logic [15:0] crc_lut(input logic [7:0] idx);
      logic [15:0] c;
      c = {8'h00, idx};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      return {8'h00, crc[15:8]} ^ crc_lut(crc[7:0] ^ b);
   endfunction

endpackage

`default_nettype wire

/* design/mrf_frame_build.sv */
`default_nettype none

module mrf_frame_build (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire mrf_pkg::req_type  in_req,
   output logic                   in_stall,
   output logic                   out_valid,
   output mrf_pkg::frame_type     out_frame,
   input  wire logic              out_stall
);
   import mrf_pkg::*;

   logic       valid_ff;
   frame_type  frame_ff, frame_in;
   logic [7:0] code;
   logic       advance;

   always_comb begin
      code = FC_NONE;
      case (in_req.reg_kind)
         KIND_COILS: begin
            if (!in_req.write_req)              code = FC_READ_COILS;
            else if (in_req.value_count == 16'd1) code = FC_WRITE_COIL;
            else                                  code = FC_WRITE_COILS;
         end
         KIND_HOLDING: begin
            code = in_req.write_req ? FC_WRITE_REG : FC_READ_HOLDING;
         end
         default: code = FC_NONE;
      endcase
   end

   always_comb begin
      frame_in         = '0;
      frame_in.data[0] = in_req.server_address;
      frame_in.data[1] = code;
      frame_in.data[2] = in_req.start_address[15:8];
      frame_in.data[3] = in_req.start_address[7:0];
      frame_in.len     = 4'd4;
      case (code)
         FC_READ_COILS, FC_READ_HOLDING: begin
            frame_in.data[4] = in_req.value_count[15:8];
            frame_in.data[5] = in_req.value_count[7:0];
            frame_in.len     = 4'd6;
         end
         FC_WRITE_REG: begin
            frame_in.data[4] = in_req.first_value[15:8];
            frame_in.data[5] = in_req.first_value[7:0];
            frame_in.len     = 4'd6;
         end
         FC_WRITE_COIL: begin
            frame_in.data[4] = (in_req.first_value != 16'd0) ? COIL_ON_SINGLE : 8'h00;
            frame_in.data[5] = 8'h00;
            frame_in.len     = 4'd6;
         end
         FC_WRITE_COILS: begin
            frame_in.data[4] = in_req.value_count[15:8];
            frame_in.data[5] = in_req.value_count[7:0];
            frame_in.data[6] = COIL_BYTE_CNT;
            frame_in.data[7] = (in_req.first_value != 16'd0) ? COIL_ON_MULTI : 8'h00;
            frame_in.len     = 4'd8;
         end
         default: frame_in.len = 4'd4;
      endcase
      frame_in.crc      = CRC_INIT;
      frame_in.pend     = frame_in.data;
      frame_in.pend_cnt = frame_in.len;
   end

   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         frame_ff <= frame_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_frame = frame_ff;

endmodule

`default_nettype wire

/* design/mrf_crc_stage.sv */
`default_nettype none

module mrf_crc_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire mrf_pkg::frame_type  in_frame,
   output logic                     in_stall,
   output logic                     out_valid,
   output mrf_pkg::frame_type       out_frame,
   input  wire logic                out_stall
);
   import mrf_pkg::*;

   logic        valid_ff;
   frame_type   frame_ff, frame_in;
   logic [15:0] crc;
   logic        advance;

   // fold up to two pending bytes, then shift the queue down
   always_comb begin
      crc = in_frame.crc;
      if (in_frame.pend_cnt != 4'd0) crc = crc_update(crc, in_frame.pend[0]);
      if (in_frame.pend_cnt > 4'd1)  crc = crc_update(crc, in_frame.pend[1]);
      frame_in          = in_frame;
      frame_in.crc      = crc;
      frame_in.pend     = in_frame.pend >> 16;
      frame_in.pend_cnt = (in_frame.pend_cnt > 4'd2) ? (in_frame.pend_cnt - 4'd2) : 4'd0;
   end

   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         frame_ff <= frame_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_frame = frame_ff;

endmodule

`default_nettype wire

/* design/mrf_serializer.sv */
`default_nettype none

module mrf_serializer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire mrf_pkg::frame_type  in_frame,
   output logic                     in_stall,
   output logic                     rsp_valid,
   output mrf_pkg::rsp_type         rsp_data,
   input  wire logic                rsp_stall
);
   import mrf_pkg::*;

   logic       valid_ff;
   frame_type  frame_ff;
   logic [3:0] pos_ff, pos_in;
   logic       last;
   logic       take;

   assign last = (pos_ff == (frame_ff.len + 4'd1));

   always_comb begin
      rsp_data.last_byte = last;
      if (pos_ff < frame_ff.len)   rsp_data.frame_byte = frame_ff.data[pos_ff[2:0]];
      else if (pos_ff == frame_ff.len) rsp_data.frame_byte = frame_ff.crc[7:0];
      else                          rsp_data.frame_byte = frame_ff.crc[15:8];
   end

   // new frame loads as the last byte of the current one leaves
   assign take     = !valid_ff || (!rsp_stall && last);
   assign in_stall = !take;
   assign pos_in   = take ? 4'd0 : ((valid_ff && !rsp_stall) ? pos_ff + 4'd1 : pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 4'd0;
      end else begin
         pos_ff <= pos_in;
         if (take) valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         frame_ff <= in_frame;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

/* design/modbus_rtu_request_framer.sv */
`default_nettype none

// Modbus RTU request framer.
//
// req_ channel: one request (register kind, write flag, server address, start
// address, value count, first value) is taken at an edge with req_valid high
// and req_stall low.
// rsp_ channel: the RTU frame leaves one byte per transfer, last_byte set on
// the CRC high byte. A frame is 6, 8 or 10 bytes: address, function code,
// start address, body, CRC-16/Modbus low then high.
//
// Path: a taken request passes the build stage, four CRC stages at two bytes
// each, then the serializer, which presents the first byte of the frame.
// The serializer holds one whole frame and takes the next only as the last
// byte of the current one leaves; requests can enter every cycle until the
// five pipeline stages fill.
// Reset clears all stage valid bits and the byte counter; no frame is in flight.
// A stall on rsp_ holds the current byte; the pipeline keeps filling behind it
// and req_stall rises once every stage holds a request.

module modbus_rtu_request_framer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire mrf_pkg::req_type req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output mrf_pkg::rsp_type      rsp_data,
   input  wire logic             rsp_stall
);
   import mrf_pkg::*;

   localparam int NUM_CRC = 4;

   // stage 0 is the build stage output, stage NUM_CRC the last CRC stage output
   logic      stg_valid [NUM_CRC+1];
   logic      stg_stall [NUM_CRC+1];
   frame_type stg_frame [NUM_CRC+1];

   mrf_frame_build u_build (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .in_stall  (req_stall),
      .out_valid (stg_valid[0]),
      .out_frame (stg_frame[0]),
      .out_stall (stg_stall[0])
   );

   for (genvar g = 0; g < NUM_CRC; g++) begin : g_crc
      mrf_crc_stage u_crc (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[g]),
         .in_frame  (stg_frame[g]),
         .in_stall  (stg_stall[g]),
         .out_valid (stg_valid[g+1]),
         .out_frame (stg_frame[g+1]),
         .out_stall (stg_stall[g+1])
      );
   end

   mrf_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid[NUM_CRC]),
      .in_frame  (stg_frame[NUM_CRC]),
      .in_stall  (stg_stall[NUM_CRC]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // a taken request lands in the build stage
   a_req_captured: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> stg_valid[0])
      else $error("request not captured by build stage");

   // all bytes ahead of the CRC are folded into it before serialization
   a_crc_done: assert property (@(posedge clock) disable iff (reset)
      stg_valid[NUM_CRC] |-> stg_frame[NUM_CRC].pend_cnt == 4'd0)
      else $error("CRC incomplete at serializer");

   // a frame never breaks up before its last byte
   a_frame_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_byte |=> rsp_valid)
      else $error("gap inside frame");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
   import mrf_pkg::*;

   // register kinds the package leaves unnamed; both yield an empty body
   localparam logic [1:0] KIND_OTHER = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic       OP_READ    = 1'b0;
   localparam logic       OP_WRITE   = 1'b1;

   localparam int RANDOM_REQUESTS = 100;
   // margin for a stray trailing byte after the last one owed
   localparam int DRAIN_CYCLES    = 40;
   // worst case: ~120 requests x 10 bytes with the longest stalls, plus gaps
   localparam int CYCLE_LIMIT     = 200000;

   // one row of the directed table; the frame is typed in only for the
   // well-known eight-byte examples, everything else goes to the predictor
   typedef struct packed {
      req_type         req;
      logic            typed;
      logic [0:7][7:0] frame;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   req_type req_data;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall;

   rsp_type      frame_bytes_due[$];   // bytes still owed by the framer, oldest first
   stim_row_type stim_table[$];
   int           mismatch_count;
   int           cycle_count;
   int           hold_left;
   bit           calm;                 // set: neither side idles or stalls

   modbus_rtu_request_framer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   always #5 clock = ~clock;

   // Idle / stall length for one request or one byte: none while calm, else half
   // the time none, otherwise a uniformly drawn length.
   function automatic int draw_wait();
      if (calm || $urandom_range(0, 1) == 0) begin
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   function automatic req_type mk_req(input logic [1:0] kind, input logic wr,
                                      input logic [7:0] srv, input logic [15:0] start,
                                      input logic [15:0] count, input logic [15:0] value);
      req_type r;
      r.reg_kind       = kind;
      r.write_req      = wr;
      r.server_address = srv;
      r.start_address  = start;
      r.value_count    = count;
      r.first_value    = value;
      return r;
   endfunction

   // Build the RTU frame for one request and queue it byte by byte.
   // CRC-16/Modbus: init 0xFFFF, reflected poly, bit-serial, no final xor.
   function automatic void predict_frame(input req_type r);
      logic [7:0]  frame[$];
      logic [7:0]  fcode;
      logic [15:0] crc;
      rsp_type     b;

      // function code select; coil write with count other than one is multi-write
      case (r.reg_kind)
         KIND_COILS:   fcode = !r.write_req ? FC_READ_COILS :
                               (r.value_count == 16'd1 ? FC_WRITE_COIL : FC_WRITE_COILS);
         KIND_HOLDING: fcode = r.write_req ? FC_WRITE_REG : FC_READ_HOLDING;
         default:      fcode = FC_NONE;
      endcase

      frame = '{r.server_address, fcode, r.start_address[15:8], r.start_address[7:0]};
      case (fcode)
         FC_READ_COILS, FC_READ_HOLDING: begin
            frame.push_back(r.value_count[15:8]);
            frame.push_back(r.value_count[7:0]);
         end
         FC_WRITE_REG: begin
            frame.push_back(r.first_value[15:8]);
            frame.push_back(r.first_value[7:0]);
         end
         FC_WRITE_COIL: begin
            frame.push_back(r.first_value != 16'd0 ? COIL_ON_SINGLE : 8'h00);
            frame.push_back(8'h00);
         end
         FC_WRITE_COILS: begin
            frame.push_back(r.value_count[15:8]);
            frame.push_back(r.value_count[7:0]);
            frame.push_back(COIL_BYTE_CNT);
            frame.push_back(r.first_value != 16'd0 ? COIL_ON_MULTI : 8'h00);
         end
         default: ;   // unknown kind: no body at all
      endcase

      crc = CRC_INIT;
      foreach (frame[i]) begin
         crc = crc ^ {8'h00, frame[i]};
         for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
         end
      end
      frame.push_back(crc[7:0]);    // CRC goes out low byte first
      frame.push_back(crc[15:8]);

      foreach (frame[i]) begin
         b.frame_byte = frame[i];
         b.last_byte  = (i == frame.size() - 1);
         frame_bytes_due.push_back(b);
      end
   endfunction

   // Present one request and hold it until the framer takes it. Called just
   // after the clock rises; with no gap drawn, req_valid stays high between requests.
   task automatic send_request(input req_type r);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Byte sink: checks each accepted byte against the oldest one owed, then
   // draws how long to stall before the next byte.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected byte, expected none, got %02h last %0b",
                        $time, rsp_data.frame_byte, rsp_data.last_byte);
            end else begin
               if (rsp_data.frame_byte !== frame_bytes_due[0].frame_byte) begin
                  mismatch_count++;
                  $display("%0t: frame_byte mismatch, expected %02h, got %02h",
                           $time, frame_bytes_due[0].frame_byte, rsp_data.frame_byte);
               end
               if (rsp_data.last_byte !== frame_bytes_due[0].last_byte) begin
                  mismatch_count++;
                  $display("%0t: last_byte mismatch, expected %0b, got %0b",
                           $time, frame_bytes_due[0].last_byte, rsp_data.last_byte);
               end
               void'(frame_bytes_due.pop_front());
            end
            hold_left = draw_wait();
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_type r;
      int      pick;

      calm           = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;

      // Directed table. The two typed frames are the textbook read-holding
      // examples; the rest cover every function code, the coil on/off
      // encodings, count of zero on coil write, unknown kinds and field extremes.
      stim_table.push_back('{mk_req(KIND_HOLDING, OP_READ, 8'h01, 16'h0000, 16'h0001, 16'h0000),
                             1'b1, {8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01, 8'h84, 8'h0A}});
      stim_table.push_back('{mk_req(KIND_HOLDING, OP_READ, 8'h11, 16'h006B, 16'h0003, 16'hFFFF),
                             1'b1, {8'h11, 8'h03, 8'h00, 8'h6B, 8'h00, 8'h03, 8'h76, 8'h87}});
      stim_table.push_back('{mk_req(KIND_COILS, OP_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_COILS, OP_READ, 8'h00, 16'h0000, 16'h0000, 16'h0000),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_COILS, OP_WRITE, 8'h05, 16'h0013, 16'h0001, 16'h0000),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_COILS, OP_WRITE, 8'hFF, 16'hFFFF, 16'h0001, 16'hFFFF),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_COILS, OP_WRITE, 8'h00, 16'h0000, 16'h0001, 16'h0001),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_COILS, OP_WRITE, 8'h2A, 16'h1234, 16'h0000, 16'h0000),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_COILS, OP_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h8000),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_COILS, OP_WRITE, 8'h01, 16'h0000, 16'h0002, 16'h0001),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_HOLDING, OP_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_HOLDING, OP_WRITE, 8'h00, 16'h0000, 16'h0000, 16'h0000),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_HOLDING, OP_WRITE, 8'h80, 16'h8000, 16'h0001, 16'h00FF),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_HOLDING, OP_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_HOLDING, OP_READ, 8'h7F, 16'h00FF, 16'h0000, 16'h0000),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_OTHER, OP_READ, 8'h03, 16'hABCD, 16'h0001, 16'h1111),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_OTHER, OP_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_SPARE, OP_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                             1'b0, '0});
      stim_table.push_back('{mk_req(KIND_SPARE, OP_WRITE, 8'h00, 16'h0000, 16'h0000, 16'h0000),
                             1'b0, '0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: the first few rows back to back with no stalls
      foreach (stim_table[i]) begin
         calm = (i < 6);
         send_request(stim_table[i].req);
         if (stim_table[i].typed) begin
            for (int k = 0; k < 8; k++) begin
               frame_bytes_due.push_back('{stim_table[i].frame[k], k == 7});
            end
         end else begin
            predict_frame(stim_table[i].req);
         end
      end

      // random part: mostly coil and holding requests, with counts biased toward
      // one and zero so that the single/multi coil split is hit often
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         calm = (n >= 40 && n < 60);   // a stretch with no idles or stalls from the bench on either side
         pick = $urandom_range(0, 9);
         r.reg_kind       = (pick < 4) ? KIND_COILS : (pick < 8) ? KIND_HOLDING :
                            (pick == 8) ? KIND_OTHER : KIND_SPARE;
         r.write_req      = 1'($urandom_range(0, 1));
         r.server_address = 8'($urandom_range(0, 255));
         r.start_address  = 16'($urandom_range(0, 65535));
         pick = $urandom_range(0, 7);
         r.value_count    = (pick == 0) ? 16'd1 : (pick == 1) ? 16'd0 :
                            (pick == 2) ? 16'hFFFF : 16'($urandom_range(0, 65535));
         pick = $urandom_range(0, 5);
         r.first_value    = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                            16'($urandom_range(0, 65535));
         send_request(r);
         predict_frame(r);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
